@@ sv/implicit_bst_search_insert_defines.svh @@
// Assertion helpers for the tree search and insert block.
`ifndef IMPLICIT_BST_SEARCH_INSERT_DEFINES_SVH
`define IMPLICIT_BST_SEARCH_INSERT_DEFINES_SVH

`ifndef SYNTHESIS
`define IBST_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibst assertion failed");
`define IBST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibst assertion failed");
`else
`define IBST_ASSERT_SAME(name, clk, rst, ante, cons)
`define IBST_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ sv/ibst_pkg.sv @@
`default_nettype none

package ibst_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 6;
   localparam int STATUS_W = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_MISSING   = 2'd1;
   localparam status_type ST_DUPLICATE = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   localparam logic FUNC_SEARCH = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

endpackage

`default_nettype wire

@@ sv/ibst_chan_if.sv @@
`default_nettype none

interface ibst_req_if;
   import ibst_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output func, output key, input ready);
   modport sink (input valid, input func, input key, output ready);
endinterface

interface ibst_rsp_if;
   import ibst_pkg::*;

   logic             valid;
   logic             ready;
   status_type       status;
   logic [POS_W-1:0] position;
   logic [POS_W-1:0] node_count;

   modport source (output valid, output status, output position, output node_count,
                   input ready);
   modport sink (input valid, input status, input position, input node_count,
                 output ready);
endinterface

`default_nettype wire

@@ sv/ibst_ram.sv @@
`default_nettype none

module ibst_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/ibst_walk.sv @@
`default_nettype none

module ibst_walk #(
   parameter int TREE_LEVELS = 6,
   parameter int KEY_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ibst_req_if.sink                    req,
   ibst_rsp_if.source                  rsp,
   output logic                        mem_we,
   output logic [TREE_LEVELS-1:0]      mem_waddr,
   output logic [KEY_BITS:0]           mem_wdata,
   output logic                        mem_re,
   output logic [TREE_LEVELS-1:0]      mem_raddr,
   input  wire logic [KEY_BITS:0]      mem_rdata
);
   import ibst_pkg::*;

   localparam int AW = TREE_LEVELS;
   localparam int CW = (TREE_LEVELS > POS_W) ? TREE_LEVELS : POS_W;
   localparam logic [AW-1:0] ROOT = AW'(1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_LOOK  = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [AW-1:0]              slot_ff, slot_in;
   logic [AW-1:0]              count_ff, count_in;
   logic                       func_ff, func_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   status_type                 hold_status_ff, hold_status_in;
   logic [AW-1:0]              hold_pos_ff, hold_pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 status_ff, status_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [POS_W-1:0]           ncnt_ff, ncnt_in;

   logic signed [KEY_BITS-1:0] key_ext;
   logic signed [KEY_BITS-1:0] stored_key;
   logic                       req_take;
   logic                       out_free;
   logic                       finish;
   status_type                 fin_status;
   logic [AW-1:0]              fin_pos;
   status_type                 src_status;
   logic [AW-1:0]              src_pos;
   logic [CW-1:0]              pos_wide;
   logic [CW-1:0]              cnt_wide;

   // Keys narrower than the port keep their low bits; wider keys are sign-extended.
   generate
      if (KEY_BITS < KEY_W) begin : g_key_narrow
         assign key_ext = req.key[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign key_ext = KEY_BITS'(req.key);
      end
   endgenerate

   assign stored_key = mem_rdata[KEY_BITS-1:0];
   assign req.ready  = (state_ff == S_IDLE);
   assign req_take   = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      slot_in        = slot_ff;
      count_in       = count_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      hold_status_in = hold_status_ff;
      hold_pos_in    = hold_pos_ff;
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      pos_in         = pos_ff;
      ncnt_in        = ncnt_ff;
      mem_we         = 1'b0;
      mem_waddr      = clr_ff;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = slot_ff;
      finish         = 1'b0;
      fin_status     = ST_MISSING;
      fin_pos        = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               func_in   = req.func;
               key_in    = key_ext;
               slot_in   = ROOT;
               mem_re    = 1'b1;
               mem_raddr = ROOT;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            // The read data belongs to slot_ff; the top bit is the slot's valid flag.
            if (!mem_rdata[KEY_BITS]) begin
               finish = 1'b1;
               if (func_ff == FUNC_INSERT) begin
                  mem_we     = 1'b1;
                  mem_waddr  = slot_ff;
                  mem_wdata  = {1'b1, key_ff};
                  count_in   = count_ff + 1'b1;
                  fin_status = ST_OK;
                  fin_pos    = slot_ff;
               end else begin
                  fin_status = ST_MISSING;
               end
            end else if (key_ff == stored_key) begin
               finish = 1'b1;
               if (func_ff == FUNC_INSERT) begin
                  fin_status = ST_DUPLICATE;
               end else begin
                  fin_status = ST_OK;
                  fin_pos    = slot_ff;
               end
            end else if (slot_ff[AW-1]) begin
               // The children of a slot on the last level lie outside the store.
               finish     = 1'b1;
               fin_status = (func_ff == FUNC_INSERT) ? ST_FULL : ST_MISSING;
            end else begin
               slot_in   = {slot_ff[AW-2:0], (key_ff > stored_key)};
               mem_re    = 1'b1;
               mem_raddr = slot_in;
            end
         end
         S_HOLD: begin
         end
         default: begin
         end
      endcase

      // The write of an insert lands before the next request can read the root.
      if (finish) begin
         if (out_free) begin
            state_in = S_IDLE;
         end else begin
            hold_status_in = fin_status;
            hold_pos_in    = fin_pos;
            state_in       = S_HOLD;
         end
      end else if (state_ff == S_HOLD && out_free) begin
         state_in = S_IDLE;
      end

      src_status = finish ? fin_status : hold_status_ff;
      src_pos    = finish ? fin_pos : hold_pos_ff;
      pos_wide   = CW'(src_pos);
      cnt_wide   = CW'(count_in);

      if (out_free && (finish || state_ff == S_HOLD)) begin
         rsp_valid_in = 1'b1;
         status_in    = src_status;
         pos_in       = pos_wide[POS_W-1:0];
         ncnt_in      = cnt_wide[POS_W-1:0];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      func_ff        <= func_in;
      key_ff         <= key_in;
      hold_status_ff <= hold_status_in;
      hold_pos_ff    <= hold_pos_in;
      status_ff      <= status_in;
      pos_ff         <= pos_in;
      ncnt_ff        <= ncnt_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.position   = pos_ff;
   assign rsp.node_count = ncnt_ff;

endmodule

`default_nettype wire

@@ sv/implicit_bst_search_insert.sv @@
// A request walks one tree level per cycle, one memory read each, visiting 1..TREE_LEVELS levels;
// its response is registered when the walk ends, or held in S_HOLD until the output register is free.
// A new request is accepted only in the idle state, after the previous walk has finished.
// A new request is taken while the previous response still waits in the output register.
// Reset: a clearing pass writes every slot of the key memory empty, during which no request
// is taken; the node count starts at zero.
`default_nettype none
`include "implicit_bst_search_insert_defines.svh"

module implicit_bst_search_insert #(
   parameter int TREE_LEVELS = 6,
   parameter int KEY_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ibst_req_if.sink   req_chan,
   ibst_rsp_if.source rsp_chan
);
   import ibst_pkg::*;

   localparam int AW = TREE_LEVELS;
   localparam int DEPTH = 2 ** TREE_LEVELS;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [KEY_BITS:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [KEY_BITS:0] mem_rdata;
   logic              req_fire;
   logic              rsp_not_ok;

   ibst_walk #(
      .TREE_LEVELS(TREE_LEVELS),
      .KEY_BITS(KEY_BITS)
   ) u_walk (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .rsp(rsp_chan),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_re(mem_re),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   // Each word holds a slot's valid flag above its key.
   ibst_ram #(
      .WIDTH(KEY_BITS + 1),
      .DEPTH(DEPTH)
   ) u_keys (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re(mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_not_ok = rsp_chan.valid && (rsp_chan.status != ST_OK);

   `IBST_ASSERT_SAME(a_pos_zero, clock, reset, rsp_not_ok, rsp_chan.position == '0)
   `IBST_ASSERT_SAME(a_take_no_write, clock, reset, req_fire, !mem_we)
   `IBST_ASSERT_SAME(a_take_reads_root, clock, reset, req_fire, mem_re && mem_raddr == AW'(1))
   `IBST_ASSERT_NEXT(a_take_busy, clock, reset, req_fire, !req_chan.ready)

endmodule

`default_nettype wire

@@ sim/implicit_bst_search_insert_tb.sv @@
`timescale 1ns / 1ps

module implicit_bst_search_insert_tb;
   import ibst_pkg::*;

   localparam int LEVELS = 6;
   localparam int SLOTS = 1 << LEVELS;
   localparam int RANDOM_REQUESTS = 2000;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MODEL_TREE = 0;
   localparam int PLAN_TREE = 1;

   typedef struct packed {
      logic                    func;
      logic signed [KEY_W-1:0] key;
   } bst_request_t;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] node_count;
   } bst_answer_t;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   errors = 0;
   int   total_requests = 0;
   int   requests_taken = 0;
   int   answers_seen = 0;
   int   req_wait = 0;
   int   rsp_wait = 0;
   int   status_seen [4];

   // Two copies of the tree: one follows the requests the block has taken, the
   // other is built ahead of time while the stimulus is planned.
   logic signed [KEY_W-1:0] tree_key [2][SLOTS];
   bit                      tree_used [2][SLOTS];
   int                      tree_size [2];

   bst_request_t request_q [$];
   bst_answer_t  answer_q [$];

   ibst_req_if req_chan ();
   ibst_rsp_if rsp_chan ();

   implicit_bst_search_insert uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bst_answer_t tree_apply(int t, logic func,
                                              logic signed [KEY_W-1:0] key);
      bst_answer_t ans;
      int          slot;
      int          level;
      bit          done;
      ans.status = (func == FUNC_INSERT) ? ST_FULL : ST_MISSING;
      ans.position = '0;
      slot = 1;
      done = 1'b0;
      for (level = 0; level < LEVELS && !done; level++) begin
         if (!tree_used[t][slot]) begin
            if (func == FUNC_INSERT) begin
               tree_key[t][slot] = key;
               tree_used[t][slot] = 1'b1;
               tree_size[t]++;
               ans.status = ST_OK;
               ans.position = POS_W'(slot);
            end else begin
               ans.status = ST_MISSING;
            end
            done = 1'b1;
         end else if (key < tree_key[t][slot]) begin
            slot = 2 * slot;
         end else if (key > tree_key[t][slot]) begin
            slot = 2 * slot + 1;
         end else begin
            if (func == FUNC_INSERT) begin
               ans.status = ST_DUPLICATE;
            end else begin
               ans.status = ST_OK;
               ans.position = POS_W'(slot);
            end
            done = 1'b1;
         end
      end
      ans.node_count = POS_W'(tree_size[t]);
      return ans;
   endfunction

   task automatic add_request(logic func, logic signed [KEY_W-1:0] key);
      bst_request_t item;
      item.func = func;
      item.key = key;
      void'(tree_apply(PLAN_TREE, func, key));
      request_q.push_back(item);
      total_requests++;
   endtask

   // Every fourth stretch of 128 requests runs with no idling at all.
   function automatic int draw_wait(int n);
      if ((n / 128) % 4 == 3) begin
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped at cycle %0d with %0d of %0d requests taken.",
                  cycle_count, requests_taken, total_requests);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_wait <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            answer_q.push_back(tree_apply(MODEL_TREE, req_chan.func, req_chan.key));
            requests_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_wait > 0) begin
               req_chan.valid <= 1'b0;
               req_wait <= req_wait - 1;
            end else if (request_q.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.func <= request_q[0].func;
               req_chan.key <= request_q[0].key;
               request_q.delete(0);
               req_wait <= draw_wait(requests_taken);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      bst_answer_t want;
      int          stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         answers_seen++;
         if (answer_q.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = answer_q.pop_front();
            status_seen[want.status]++;
            if (rsp_chan.status !== want.status) begin
               report_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                         answers_seen, rsp_chan.status, want.status));
            end
            if (rsp_chan.position !== want.position) begin
               report_mismatch($sformatf("response %0d: position %0d, expected %0d",
                                         answers_seen, rsp_chan.position, want.position));
            end
            if (rsp_chan.node_count !== want.node_count) begin
               report_mismatch($sformatf("response %0d: node_count %0d, expected %0d",
                                         answers_seen, rsp_chan.node_count,
                                         want.node_count));
            end
         end
         stall = draw_wait(answers_seen);
         rsp_wait <= stall;
         rsp_chan.ready <= (stall == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_chan.ready <= (rsp_wait == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin : stimulus
      int                      open_slots [$];
      int                      n;
      int                      r;
      int                      pick;
      int                      slot;
      int                      up;
      longint                  lo;
      longint                  hi;
      longint                  bound;
      logic signed [KEY_W-1:0] key;
      bit                      placed;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_SEARCH;
      req_chan.key = '0;
      rsp_chan.ready = 1'b0;

      // Empty tree, root insert, duplicate, a hit at the root and a miss below it.
      add_request(FUNC_SEARCH, 32'sh8000_0000);
      add_request(FUNC_INSERT, 32'sh0000_0000);
      add_request(FUNC_INSERT, 32'sh0000_0000);
      add_request(FUNC_SEARCH, 32'sh0000_0000);
      add_request(FUNC_SEARCH, 32'sh7FFF_FFFF);
      // A path down to the last level with wide gaps left for later inserts.
      add_request(FUNC_INSERT, 32'shC000_0000);
      add_request(FUNC_INSERT, 32'sh4000_0000);
      add_request(FUNC_INSERT, 32'sh2000_0000);
      add_request(FUNC_INSERT, 32'sh3000_0000);
      add_request(FUNC_INSERT, 32'sh2800_0000);
      add_request(FUNC_INSERT, 32'sh2400_0000);
      // This one runs off the bottom of the tree, both as insert and search.
      add_request(FUNC_INSERT, 32'sh2200_0000);
      add_request(FUNC_SEARCH, 32'sh2200_0000);
      add_request(FUNC_SEARCH, 32'sh2400_0000);
      add_request(FUNC_INSERT, -32'sd1);
      // Searches that stop early at an empty slot.
      add_request(FUNC_SEARCH, -32'sd2);
      add_request(FUNC_SEARCH, 32'sh8000_0000);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            // Pick an empty slot right below a stored key and a key that lands there,
            // so the tree fills level by level down to the bottom.
            open_slots.delete();
            for (slot = 1; slot < SLOTS; slot++) begin
               if (!tree_used[PLAN_TREE][slot] &&
                   (slot == 1 || tree_used[PLAN_TREE][slot / 2])) begin
                  open_slots.push_back(slot);
               end
            end
            placed = 1'b0;
            while (!placed && open_slots.size() > 0) begin
               pick = $urandom_range(0, open_slots.size() - 1);
               slot = open_slots[pick];
               open_slots.delete(pick);
               lo = -64'sd2147483649;
               hi = 64'sd2147483648;
               for (up = slot; up > 1; up = up / 2) begin
                  bound = tree_key[PLAN_TREE][up / 2];
                  if (up % 2 == 0 && bound < hi) begin
                     hi = bound;
                  end
                  if (up % 2 == 1 && bound > lo) begin
                     lo = bound;
                  end
               end
               if (hi - lo > 1) begin
                  key = KEY_W'(lo + 1 + longint'($urandom) % (hi - lo - 1));
                  add_request(FUNC_INSERT, key);
                  placed = 1'b1;
               end
            end
            if (!placed) begin
               add_request(FUNC_INSERT, $urandom);
            end
         end else if (r < 65) begin
            do begin
               slot = $urandom_range(1, SLOTS - 1);
            end while (!tree_used[PLAN_TREE][slot]);
            key = tree_key[PLAN_TREE][slot];
            if (r < 45) begin
               add_request(FUNC_SEARCH, key);
            end else if (r < 55) begin
               add_request(FUNC_INSERT, key);
            end else begin
               // Near misses just beside a stored key.
               key = $urandom_range(0, 1) ? key + 1 : key - 1;
               add_request(FUNC_SEARCH, key);
            end
         end else if (r < 80) begin
            add_request(FUNC_SEARCH, $urandom);
         end else begin
            add_request($urandom_range(0, 1) ? FUNC_INSERT : FUNC_SEARCH, $urandom);
         end
      end
      add_request(FUNC_INSERT, 32'sh8000_0000);
      add_request(FUNC_INSERT, 32'sh7FFF_FFFF);
      add_request(FUNC_SEARCH, 32'sh7FFF_FFFF);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < total_requests || answer_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d requests: %0d found or inserted, %0d missing, %0d duplicates, %0d full paths.",
               answers_seen, status_seen[ST_OK], status_seen[ST_MISSING],
               status_seen[ST_DUPLICATE], status_seen[ST_FULL]);
      $display("The tree held %0d keys at the end; %0d errors.",
               tree_size[MODEL_TREE], errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
